@@ rtl/core/sil_pkg.sv @@
package sil_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_ELEMENT  = 2'd2,
    ST_EMPTY    = 2'd3
  } sil_status_t;

  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_DISPLAY = 1'b1
  } sil_cmd_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_LIST = 1'b1
  } sil_state_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic                     insert;
    logic                     rotate;
    logic signed [DATA_W-1:0] value;
  } sil_cell_ctrl_t;

endpackage

@@ rtl/core/sil_cell.sv @@
module sil_cell
  import sil_pkg::*;
(
  input  logic                     clk,
  input  sil_cell_ctrl_t           ctrl,
  input  logic                     occupied,
  input  logic                     at_count,
  input  logic                     at_end,
  input  logic                     left_gt,
  input  logic signed [DATA_W-1:0] left_val,
  input  logic signed [DATA_W-1:0] right_val,
  input  logic signed [DATA_W-1:0] wrap_val,
  output logic                     gt,
  output logic signed [DATA_W-1:0] val
);

  logic signed [DATA_W-1:0] val_next;

  // Entries strictly greater than the new value move up one cell, so an
  // equal value stays below the new one.
  assign gt = occupied && (val > ctrl.value);

  always_comb begin
    val_next = val;
    if (ctrl.insert) begin
      if (left_gt) begin
        val_next = left_val;
      end else if (gt || at_count) begin
        val_next = ctrl.value;
      end
    end else if (ctrl.rotate && occupied) begin
      // The occupied part of the chain turns one step toward cell zero.
      val_next = at_end ? wrap_val : right_val;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

@@ rtl/core/sorted_insertion_list_unit.sv @@
// Insert: the status word of a taken word appears on the output register the next cycle;
// inserts can follow every cycle while the output drains.
// Display of N entries: once the FSM is in the listing state, elements load one per cycle
// while the output drains as the cells rotate; the next word is taken after the last loads.
// Reset (rst, synchronous) empties the list and the output register; the cell
// contents are left as they are and are never read until written again.
module sorted_insertion_list_unit
  import sil_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
  input  logic              s_tuser,   // [0] command
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // [31:0] element
  output logic [1:0]        m_tuser,   // [1:0] status
  output logic              m_tlast
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  sil_state_t               state, state_next;
  logic [CW-1:0]            cnt, cnt_next;
  logic [IW-1:0]            idx, idx_next;
  sil_cell_ctrl_t           ctrl;
  logic                     can_load;
  logic                     load;
  logic                     full;
  logic                     accept;
  logic                     last_idx;
  logic [1:0]               out_status;
  logic [DATA_W-1:0]        out_element;
  logic                     out_last;

  logic                     gt_v   [CAPACITY];
  logic signed [DATA_W-1:0] val_v  [CAPACITY];

  assign can_load = !m_tvalid || m_tready;
  assign full     = (cnt == CW'(CAPACITY));
  assign accept   = s_tvalid && s_tready;
  assign last_idx = (CW'(idx) == CW'(cnt - CW'(1)));

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      sil_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .occupied (cnt > CW'(g)),
        .at_count (cnt == CW'(g)),
        .at_end   (cnt == CW'(g + 1)),
        .left_gt  ((g == 0) ? 1'b0 : gt_v[(g == 0) ? 0 : g - 1]),
        .left_val (val_v[(g == 0) ? 0 : g - 1]),
        .right_val(val_v[(g == CAPACITY - 1) ? 0 : g + 1]),
        .wrap_val (val_v[0]),
        .gt       (gt_v[g]),
        .val      (val_v[g])
      );
    end
  endgenerate

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (accept && (sil_cmd_t'(s_tuser) == CMD_DISPLAY) && (cnt != '0)) begin
          state_next = FSM_LIST;
        end
      end
      FSM_LIST: begin
        if (can_load && last_idx) begin
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    s_tready    = 1'b0;
    load        = 1'b0;
    out_status  = ST_INSERTED;
    out_element = '0;
    out_last    = 1'b1;
    ctrl.insert = 1'b0;
    ctrl.rotate = 1'b0;
    ctrl.value  = s_tdata;
    cnt_next    = cnt;
    idx_next    = idx;
    unique case (state)
      FSM_IDLE: begin
        s_tready = can_load;
        idx_next = '0;
        if (accept) begin
          if (sil_cmd_t'(s_tuser) == CMD_INSERT) begin
            load = 1'b1;
            if (full) begin
              out_status = ST_FULL;
            end else begin
              out_status  = ST_INSERTED;
              ctrl.insert = 1'b1;
              cnt_next    = cnt + CW'(1);
            end
          end else if (cnt == '0) begin
            load       = 1'b1;
            out_status = ST_EMPTY;
          end
        end
      end
      FSM_LIST: begin
        if (can_load) begin
          load        = 1'b1;
          out_status  = ST_ELEMENT;
          out_element = val_v[0];
          out_last    = last_idx;
          ctrl.rotate = 1'b1;
          idx_next    = idx + IW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FSM_IDLE;
      cnt      <= '0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      idx   <= idx_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= out_element;
      m_tuser <= out_status;
      m_tlast <= out_last;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_list_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_LIST) |-> (cnt != '0))
    else $error("listing an empty store");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && (sil_cmd_t'(s_tuser) == CMD_INSERT) && !full) |=> (cnt == $past(cnt) + CW'(1)))
    else $error("insert did not grow the list");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && (sil_cmd_t'(s_tuser) == CMD_INSERT) && full) |=> $stable(cnt))
    else $error("dropped insert changed the count");

  a_list_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_LIST) |-> !s_tready)
    else $error("word accepted during listing");
`endif

endmodule

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sil_pkg::*;

  typedef logic signed [DATA_W-1:0] entry_t;

  typedef struct {
    sil_status_t status;
    entry_t      element;
    logic        last;
  } list_result_t;

  localparam entry_t MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
  localparam entry_t MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam int     RANDOM_WORDS = 450;
  localparam int     IDLE_LIMIT = 500;
  localparam int     TAIL_CYCLES = 20;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic [1:0]        m_tuser;
  logic              m_tlast;

  // Shadow copy of the sorted store and the results still to come out.
  entry_t       held_values[$];
  list_result_t awaited_results[$];
  int           mismatches = 0;
  bit           steady = 1'b0;

  sorted_insertion_list_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // A new value goes after every equal value already held.
  function void predict_list_results(sil_cmd_t cmd, entry_t value);
    int slot;
    if (cmd == CMD_INSERT) begin
      if (held_values.size() >= CAPACITY_DEF) begin
        awaited_results.push_back('{ST_FULL, '0, 1'b1});
      end else begin
        slot = held_values.size();
        while (slot > 0 && held_values[slot-1] > value) slot--;
        held_values.insert(slot, value);
        awaited_results.push_back('{ST_INSERTED, '0, 1'b1});
      end
    end else if (held_values.size() == 0) begin
      awaited_results.push_back('{ST_EMPTY, '0, 1'b1});
    end else begin
      foreach (held_values[i]) begin
        awaited_results.push_back('{ST_ELEMENT, held_values[i], i == held_values.size() - 1});
      end
    end
  endfunction

  task automatic send_word(sil_cmd_t cmd, entry_t value);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    predict_list_results(cmd, value);
  endtask

  task automatic test_empty_list();
    send_word(CMD_DISPLAY, $urandom);
  endtask

  task automatic test_extremes_and_ties();
    send_word(CMD_INSERT, MOST_NEG);
    send_word(CMD_INSERT, MOST_POS);
    send_word(CMD_INSERT, 0);
    send_word(CMD_INSERT, -1);
    send_word(CMD_INSERT, 1);
    send_word(CMD_INSERT, 0);
    send_word(CMD_INSERT, MOST_POS);
    send_word(CMD_INSERT, MOST_NEG);
    send_word(CMD_DISPLAY, $urandom);
  endtask

  task automatic test_full_store();
    // Small values make ties likely among the remaining entries.
    while (held_values.size() < CAPACITY_DEF) begin
      send_word(CMD_INSERT, entry_t'($urandom_range(0, 6)) - 3);
    end
    send_word(CMD_DISPLAY, $urandom);
    send_word(CMD_INSERT, MOST_POS);
    send_word(CMD_INSERT, MOST_NEG);
    send_word(CMD_DISPLAY, $urandom);
  endtask

  task automatic test_drain_pause();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic test_random_traffic();
    sil_cmd_t cmd;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_WORDS / 2) test_drain_pause();
      cmd = ($urandom_range(0, 9) < 3) ? CMD_DISPLAY : CMD_INSERT;
      send_word(cmd, $urandom);
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_extremes_and_ties();
    test_full_store();
    test_random_traffic();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word status=%0d element=%0d last=%0b",
                 $time, m_tuser, $signed(m_tdata), m_tlast);
      end else begin
        want = awaited_results.pop_front();
        if (m_tuser !== want.status || m_tdata !== want.element || m_tlast !== want.last) begin
          mismatches++;
          $display("%0t: expected status=%0d element=%0d last=%0b, got %0d %0d %0b",
                   $time, want.status, want.element, want.last,
                   m_tuser, $signed(m_tdata), m_tlast);
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which neither side moves a word.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/sil_pkg.sv
rtl/core/sil_cell.sv
rtl/core/sorted_insertion_list_unit.sv
test/testbench.sv
